// ===== sv/ebcid_pkg.sv =====
`default_nettype none
package ebcid_pkg;

    typedef struct packed {
        logic [7:0] opcode_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } in_item_t;

    typedef struct packed {
        logic        illegal;
        logic [5:0]  operation;
        logic [2:0]  condition;
        logic [2:0]  first_kind;
        logic [15:0] first_value;
        logic [2:0]  second_kind;
        logic [15:0] second_value;
    } out_item_t;

    // operand kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_REG   = 3'd1;
    localparam logic [2:0] K_PAIR  = 3'd2;
    localparam logic [2:0] K_IND   = 3'd3;
    localparam logic [2:0] K_IMM8  = 3'd4;
    localparam logic [2:0] K_IMM16 = 3'd5;
    localparam logic [2:0] K_ADDR  = 3'd6;

    // register and pair codes
    localparam logic [15:0] R_A  = 16'd0;
    localparam logic [15:0] R_C  = 16'd2;
    localparam logic [15:0] P_AF = 16'd0;
    localparam logic [15:0] P_HL = 16'd3;
    localparam logic [15:0] P_SP = 16'd4;

    // operation codes
    localparam logic [5:0] OP_NOP  = 6'd0;
    localparam logic [5:0] OP_LD   = 6'd1;
    localparam logic [5:0] OP_INC  = 6'd2;
    localparam logic [5:0] OP_DEC  = 6'd3;
    localparam logic [5:0] OP_RLCA = 6'd4;
    localparam logic [5:0] OP_ADD  = 6'd5;
    localparam logic [5:0] OP_RRCA = 6'd6;
    localparam logic [5:0] OP_STOP = 6'd7;
    localparam logic [5:0] OP_RLA  = 6'd8;
    localparam logic [5:0] OP_JR   = 6'd9;
    localparam logic [5:0] OP_RRA  = 6'd10;
    localparam logic [5:0] OP_LDI  = 6'd11;
    localparam logic [5:0] OP_DAA  = 6'd12;
    localparam logic [5:0] OP_CPL  = 6'd13;
    localparam logic [5:0] OP_LDD  = 6'd14;
    localparam logic [5:0] OP_SCF  = 6'd15;
    localparam logic [5:0] OP_CCF  = 6'd16;
    localparam logic [5:0] OP_HALT = 6'd17;
    localparam logic [5:0] OP_ADC  = 6'd18;
    localparam logic [5:0] OP_SUB  = 6'd19;
    localparam logic [5:0] OP_SBC  = 6'd20;
    localparam logic [5:0] OP_AND  = 6'd21;
    localparam logic [5:0] OP_XOR  = 6'd22;
    localparam logic [5:0] OP_OR   = 6'd23;
    localparam logic [5:0] OP_CP   = 6'd24;
    localparam logic [5:0] OP_RET  = 6'd25;
    localparam logic [5:0] OP_POP  = 6'd26;
    localparam logic [5:0] OP_JP   = 6'd27;
    localparam logic [5:0] OP_CALL = 6'd28;
    localparam logic [5:0] OP_PUSH = 6'd29;
    localparam logic [5:0] OP_RST  = 6'd30;
    localparam logic [5:0] OP_RETI = 6'd31;
    localparam logic [5:0] OP_LDH  = 6'd32;
    localparam logic [5:0] OP_DI   = 6'd33;
    localparam logic [5:0] OP_LDHL = 6'd34;
    localparam logic [5:0] OP_EI   = 6'd35;

    localparam logic [7:0] OPC_HALT = 8'h76;

    // 3-bit register field to register code
    function automatic logic [15:0] reg_code(input logic [2:0] r);
        logic [15:0] v;
        case (r)
            3'd0: v = 16'd1;
            3'd1: v = 16'd2;
            3'd2: v = 16'd3;
            3'd3: v = 16'd4;
            3'd4: v = 16'd5;
            3'd5: v = 16'd6;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pair_sp(input logic [1:0] p);
        return {13'd0, 1'b0, p} + 16'd1;
    endfunction

    function automatic logic [15:0] pair_af(input logic [1:0] p);
        return (p == 2'd3) ? P_AF : ({14'd0, p} + 16'd1);
    endfunction

    function automatic logic [5:0] rot_op(input logic [2:0] y);
        logic [5:0] v;
        case (y)
            3'd0: v = OP_RLCA;
            3'd1: v = OP_RRCA;
            3'd2: v = OP_RLA;
            3'd3: v = OP_RRA;
            3'd4: v = OP_DAA;
            3'd5: v = OP_CPL;
            3'd6: v = OP_SCF;
            default: v = OP_CCF;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] alu_op(input logic [2:0] y);
        logic [5:0] v;
        case (y)
            3'd0: v = OP_ADD;
            3'd1: v = OP_ADC;
            3'd2: v = OP_SUB;
            3'd3: v = OP_SBC;
            3'd4: v = OP_AND;
            3'd5: v = OP_XOR;
            3'd6: v = OP_OR;
            default: v = OP_CP;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ebcid_decode.sv =====
`default_nettype none
module ebcid_decode (
    input  wire  ebcid_pkg::in_item_t  item,
    output ebcid_pkg::out_item_t       dec
);

    logic [1:0]  x;
    logic [2:0]  y;
    logic [2:0]  z;
    logic [1:0]  p;
    logic        q;
    logic [15:0] imm16;
    logic [15:0] b1;
    logic [15:0] rv1;
    logic [15:0] rv2;
    logic [2:0]  rk1;
    logic [2:0]  rk2;
    logic        alu_acc;

    assign x = item.opcode_byte[7:6];
    assign y = item.opcode_byte[5:3];
    assign z = item.opcode_byte[2:0];
    assign p = y[2:1];
    assign q = y[0];
    assign imm16 = {item.second_byte, item.third_byte};
    assign b1 = {8'd0, item.second_byte};
    assign alu_acc = (y == 3'd0) || (y == 3'd1) || (y == 3'd3);

    // register operand from y (first) and z (second) fields
    assign rk1 = (y == 3'd6) ? ebcid_pkg::K_IND : ebcid_pkg::K_REG;
    assign rv1 = (y == 3'd6) ? ebcid_pkg::P_HL : ebcid_pkg::reg_code(y);
    assign rk2 = (z == 3'd6) ? ebcid_pkg::K_IND : ebcid_pkg::K_REG;
    assign rv2 = (z == 3'd6) ? ebcid_pkg::P_HL : ebcid_pkg::reg_code(z);

    // decode one opcode
    always_comb begin
        dec = '0;
        case (x)
            2'd1: begin
                if (item.opcode_byte == ebcid_pkg::OPC_HALT) begin
                    dec.operation = ebcid_pkg::OP_HALT;
                end else begin
                    dec.operation = ebcid_pkg::OP_LD;
                    dec.first_kind = rk1;  dec.first_value = rv1;
                    dec.second_kind = rk2; dec.second_value = rv2;
                end
            end
            2'd2: begin
                dec.operation = ebcid_pkg::alu_op(y);
                if (alu_acc) begin
                    dec.first_kind = ebcid_pkg::K_REG; dec.first_value = ebcid_pkg::R_A;
                    dec.second_kind = rk2; dec.second_value = rv2;
                end else begin
                    dec.first_kind = rk2; dec.first_value = rv2;
                end
            end
            2'd0: begin
                case (z)
                    3'd0: begin
                        case (y)
                            3'd0: dec.operation = ebcid_pkg::OP_NOP;
                            3'd1: begin
                                dec.operation = ebcid_pkg::OP_LD;
                                dec.first_kind = ebcid_pkg::K_ADDR;
                                dec.first_value = imm16;
                                dec.second_kind = ebcid_pkg::K_PAIR;
                                dec.second_value = ebcid_pkg::P_SP;
                            end
                            3'd2: dec.operation = ebcid_pkg::OP_STOP;
                            default: begin
                                dec.operation = ebcid_pkg::OP_JR;
                                dec.first_kind = ebcid_pkg::K_ADDR;
                                dec.first_value = b1;
                                if (y[2]) begin
                                    dec.condition = y - 3'd3;
                                end
                            end
                        endcase
                    end
                    3'd1: begin
                        if (!q) begin
                            dec.operation = ebcid_pkg::OP_LD;
                            dec.first_kind = ebcid_pkg::K_PAIR;
                            dec.first_value = ebcid_pkg::pair_sp(p);
                            dec.second_kind = ebcid_pkg::K_IMM16;
                            dec.second_value = imm16;
                        end else begin
                            dec.operation = ebcid_pkg::OP_ADD;
                            dec.first_kind = ebcid_pkg::K_PAIR;
                            dec.first_value = ebcid_pkg::P_HL;
                            dec.second_kind = ebcid_pkg::K_PAIR;
                            dec.second_value = ebcid_pkg::pair_sp(p);
                        end
                    end
                    3'd2: begin
                        case (p)
                            2'd2: dec.operation = ebcid_pkg::OP_LDI;
                            2'd3: dec.operation = ebcid_pkg::OP_LDD;
                            default: dec.operation = ebcid_pkg::OP_LD;
                        endcase
                        if (!q) begin
                            dec.first_kind = ebcid_pkg::K_IND;
                            dec.first_value = p[1] ? ebcid_pkg::P_HL : ebcid_pkg::pair_sp(p);
                            dec.second_kind = ebcid_pkg::K_REG;
                            dec.second_value = ebcid_pkg::R_A;
                        end else begin
                            dec.first_kind = ebcid_pkg::K_REG;
                            dec.first_value = ebcid_pkg::R_A;
                            dec.second_kind = ebcid_pkg::K_IND;
                            dec.second_value = p[1] ? ebcid_pkg::P_HL : ebcid_pkg::pair_sp(p);
                        end
                    end
                    3'd3: begin
                        dec.operation = q ? ebcid_pkg::OP_DEC : ebcid_pkg::OP_INC;
                        dec.first_kind = ebcid_pkg::K_PAIR;
                        dec.first_value = ebcid_pkg::pair_sp(p);
                    end
                    3'd4: begin
                        dec.operation = ebcid_pkg::OP_INC;
                        dec.first_kind = rk1; dec.first_value = rv1;
                    end
                    3'd5: begin
                        dec.operation = ebcid_pkg::OP_DEC;
                        dec.first_kind = rk1; dec.first_value = rv1;
                    end
                    3'd6: begin
                        dec.operation = ebcid_pkg::OP_LD;
                        dec.first_kind = rk1; dec.first_value = rv1;
                        dec.second_kind = ebcid_pkg::K_IMM8; dec.second_value = b1;
                    end
                    default: dec.operation = ebcid_pkg::rot_op(y);
                endcase
            end
            default: begin
                case (z)
                    3'd0: begin
                        case (y)
                            3'd4: begin
                                dec.operation = ebcid_pkg::OP_LDH;
                                dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = b1;
                                dec.second_kind = ebcid_pkg::K_REG;
                                dec.second_value = ebcid_pkg::R_A;
                            end
                            3'd5: begin
                                dec.operation = ebcid_pkg::OP_ADD;
                                dec.first_kind = ebcid_pkg::K_PAIR;
                                dec.first_value = ebcid_pkg::P_SP;
                                dec.second_kind = ebcid_pkg::K_IMM8; dec.second_value = b1;
                            end
                            3'd6: begin
                                dec.operation = ebcid_pkg::OP_LDH;
                                dec.first_kind = ebcid_pkg::K_REG;
                                dec.first_value = ebcid_pkg::R_A;
                                dec.second_kind = ebcid_pkg::K_ADDR; dec.second_value = b1;
                            end
                            3'd7: begin
                                dec.operation = ebcid_pkg::OP_LDHL;
                                dec.first_kind = ebcid_pkg::K_PAIR;
                                dec.first_value = ebcid_pkg::P_SP;
                                dec.second_kind = ebcid_pkg::K_IMM8; dec.second_value = b1;
                            end
                            default: begin
                                dec.operation = ebcid_pkg::OP_RET;
                                dec.condition = y + 3'd1;
                            end
                        endcase
                    end
                    3'd1: begin
                        if (!q) begin
                            dec.operation = ebcid_pkg::OP_POP;
                            dec.first_kind = ebcid_pkg::K_PAIR;
                            dec.first_value = ebcid_pkg::pair_af(p);
                        end else begin
                            case (p)
                                2'd0: dec.operation = ebcid_pkg::OP_RET;
                                2'd1: dec.operation = ebcid_pkg::OP_RETI;
                                2'd2: begin
                                    dec.operation = ebcid_pkg::OP_JP;
                                    dec.first_kind = ebcid_pkg::K_IND;
                                    dec.first_value = ebcid_pkg::P_HL;
                                end
                                default: begin
                                    dec.operation = ebcid_pkg::OP_LD;
                                    dec.first_kind = ebcid_pkg::K_PAIR;
                                    dec.first_value = ebcid_pkg::P_SP;
                                    dec.second_kind = ebcid_pkg::K_PAIR;
                                    dec.second_value = ebcid_pkg::P_HL;
                                end
                            endcase
                        end
                    end
                    3'd2: begin
                        case (y)
                            3'd4: begin
                                dec.operation = ebcid_pkg::OP_LDH;
                                dec.first_kind = ebcid_pkg::K_REG;
                                dec.first_value = ebcid_pkg::R_C;
                                dec.second_kind = ebcid_pkg::K_REG;
                                dec.second_value = ebcid_pkg::R_A;
                            end
                            3'd5: begin
                                dec.operation = ebcid_pkg::OP_LD;
                                dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = imm16;
                                dec.second_kind = ebcid_pkg::K_REG;
                                dec.second_value = ebcid_pkg::R_A;
                            end
                            3'd6: begin
                                dec.operation = ebcid_pkg::OP_LDH;
                                dec.first_kind = ebcid_pkg::K_REG;
                                dec.first_value = ebcid_pkg::R_A;
                                dec.second_kind = ebcid_pkg::K_REG;
                                dec.second_value = ebcid_pkg::R_C;
                            end
                            3'd7: begin
                                dec.operation = ebcid_pkg::OP_LD;
                                dec.first_kind = ebcid_pkg::K_REG;
                                dec.first_value = ebcid_pkg::R_A;
                                dec.second_kind = ebcid_pkg::K_ADDR; dec.second_value = imm16;
                            end
                            default: begin
                                dec.operation = ebcid_pkg::OP_JP;
                                dec.condition = y + 3'd1;
                                dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = imm16;
                            end
                        endcase
                    end
                    3'd3: begin
                        case (y)
                            3'd0: begin
                                dec.operation = ebcid_pkg::OP_JP;
                                dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = imm16;
                            end
                            3'd6: dec.operation = ebcid_pkg::OP_DI;
                            3'd7: dec.operation = ebcid_pkg::OP_EI;
                            default: dec.illegal = 1'b1;
                        endcase
                    end
                    3'd4: begin
                        if (!y[2]) begin
                            dec.operation = ebcid_pkg::OP_CALL;
                            dec.condition = y + 3'd1;
                            dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = imm16;
                        end else begin
                            dec.illegal = 1'b1;
                        end
                    end
                    3'd5: begin
                        if (!q) begin
                            dec.operation = ebcid_pkg::OP_PUSH;
                            dec.first_kind = ebcid_pkg::K_PAIR;
                            dec.first_value = ebcid_pkg::pair_af(p);
                        end else if (p == 2'd0) begin
                            dec.operation = ebcid_pkg::OP_CALL;
                            dec.first_kind = ebcid_pkg::K_ADDR; dec.first_value = imm16;
                        end else begin
                            dec.illegal = 1'b1;
                        end
                    end
                    3'd6: begin
                        dec.operation = ebcid_pkg::alu_op(y);
                        if (alu_acc) begin
                            dec.first_kind = ebcid_pkg::K_REG;
                            dec.first_value = ebcid_pkg::R_A;
                            dec.second_kind = ebcid_pkg::K_IMM8; dec.second_value = b1;
                        end else begin
                            dec.first_kind = ebcid_pkg::K_IMM8; dec.first_value = b1;
                        end
                    end
                    default: begin
                        dec.operation = ebcid_pkg::OP_RST;
                        dec.first_kind = ebcid_pkg::K_ADDR;
                        dec.first_value = {10'd0, y, 3'd0};
                    end
                endcase
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/eight_bit_cpu_instruction_decoder_top.sv =====
// Path: an accepted item enters the input register, is decoded between the registers,
//   and is loaded into the result register when that stage is free or drains.
// Throughput: 1 item per cycle unless m_ready stalls, set by the single decode pass.
// Reset: aresetn synchronous active low clears both valid flags; no item is held.
`default_nettype none
module eight_bit_cpu_instruction_decoder_top (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  ebcid_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output ebcid_pkg::out_item_t       m_data
);

    logic                  in_valid_reg;
    ebcid_pkg::in_item_t   in_data_reg;
    logic                  out_valid_reg;
    ebcid_pkg::out_item_t  out_data_reg;
    ebcid_pkg::out_item_t  dec;
    logic                  out_load;
    logic                  in_ready;

    ebcid_decode u_decode (
        .item (in_data_reg),
        .dec  (dec)
    );

    // advance when the result stage is free or drains this cycle
    assign out_load = !out_valid_reg || m_ready;
    assign in_ready = !in_valid_reg || out_load;
    assign s_ready  = in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // hold input item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // hold decoded result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= dec;
        end
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("decoded item lost");
    a_illegal_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.illegal |-> m_data.operation == ebcid_pkg::OP_NOP
        && m_data.first_kind == ebcid_pkg::K_NONE)
        else $error("illegal item carries fields");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty result stage");
`endif

endmodule
`default_nettype wire

// ===== bench/decoder_checker.sv =====
module decoder_checker (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    input  wire                        s_ready,
    input  wire  ebcid_pkg::in_item_t  s_data,
    input  wire                        m_valid,
    input  wire                        m_ready,
    input  wire  ebcid_pkg::out_item_t m_data,
    output int                         fail_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ebcid_pkg::*;

    out_item_t decoded_queue[$];

    // Map the 3-bit register field; field 6 means (HL)
    function automatic void reg_operand(input logic [2:0] r, output logic [2:0] k,
                                        output logic [15:0] v);
        k = K_REG;
        case (r)
            3'd0: v = 16'd1;
            3'd1: v = 16'd2;
            3'd2: v = 16'd3;
            3'd3: v = 16'd4;
            3'd4: v = 16'd5;
            3'd5: v = 16'd6;
            3'd6: begin
                k = K_IND;
                v = P_HL;
            end
            default: v = R_A;
        endcase
    endfunction

    function automatic logic [5:0] alu_class(input logic [2:0] y);
        logic [5:0] t [8];
        t = '{OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_CP};
        return t[y];
    endfunction

    // Decode one instruction into its expected fields
    function automatic out_item_t decode_instr(input in_item_t it);
        out_item_t d;
        logic [1:0] x, p;
        logic [2:0] y, z;
        logic q;
        logic [15:0] imm16, b1, pr_sp, pr_af;
        logic [5:0] rot [8];
        logic accum;
        rot = '{OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_DAA, OP_CPL, OP_SCF, OP_CCF};
        d = '0;
        x = it.opcode_byte[7:6];
        y = it.opcode_byte[5:3];
        z = it.opcode_byte[2:0];
        p = y[2:1];
        q = y[0];
        b1 = {8'd0, it.second_byte};
        imm16 = {it.second_byte, it.third_byte};
        pr_sp = {14'd0, p} + 16'd1;
        pr_af = (p == 2'd3) ? P_AF : ({14'd0, p} + 16'd1);
        accum = (y == 3'd0 || y == 3'd1 || y == 3'd3);
        if (x == 2'd1) begin
            if (it.opcode_byte == OPC_HALT) begin
                d.operation = OP_HALT;
            end else begin
                d.operation = OP_LD;
                reg_operand(y, d.first_kind, d.first_value);
                reg_operand(z, d.second_kind, d.second_value);
            end
        end else if (x == 2'd2 || (x == 2'd3 && z == 3'd6)) begin
            // ALU group; ADD, ADC, SBC name A explicitly
            d.operation = alu_class(y);
            if (accum) begin
                d.first_kind = K_REG;
                d.first_value = R_A;
                if (x == 2'd3) begin
                    d.second_kind = K_IMM8;
                    d.second_value = b1;
                end else begin
                    reg_operand(z, d.second_kind, d.second_value);
                end
            end else if (x == 2'd3) begin
                d.first_kind = K_IMM8;
                d.first_value = b1;
            end else begin
                reg_operand(z, d.first_kind, d.first_value);
            end
        end else if (x == 2'd0) begin
            case (z)
                3'd0: begin
                    if (y == 3'd1) begin
                        d.operation = OP_LD;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                        d.second_kind = K_PAIR; d.second_value = P_SP;
                    end else if (y == 3'd2) begin
                        d.operation = OP_STOP;
                    end else if (y != 3'd0) begin
                        d.operation = OP_JR;
                        d.first_kind = K_ADDR; d.first_value = b1;
                        if (y >= 3'd4) d.condition = y - 3'd3;
                    end
                end
                3'd1: begin
                    if (!q) begin
                        d.operation = OP_LD;
                        d.first_kind = K_PAIR; d.first_value = pr_sp;
                        d.second_kind = K_IMM16; d.second_value = imm16;
                    end else begin
                        d.operation = OP_ADD;
                        d.first_kind = K_PAIR; d.first_value = P_HL;
                        d.second_kind = K_PAIR; d.second_value = pr_sp;
                    end
                end
                3'd2: begin
                    d.operation = (p == 2'd2) ? OP_LDI : (p == 2'd3) ? OP_LDD : OP_LD;
                    if (!q) begin
                        d.first_kind = K_IND;
                        d.first_value = (p < 2'd2) ? pr_sp : P_HL;
                        d.second_kind = K_REG; d.second_value = R_A;
                    end else begin
                        d.first_kind = K_REG; d.first_value = R_A;
                        d.second_kind = K_IND;
                        d.second_value = (p < 2'd2) ? pr_sp : P_HL;
                    end
                end
                3'd3: begin
                    d.operation = q ? OP_DEC : OP_INC;
                    d.first_kind = K_PAIR; d.first_value = pr_sp;
                end
                3'd4: begin
                    d.operation = OP_INC;
                    reg_operand(y, d.first_kind, d.first_value);
                end
                3'd5: begin
                    d.operation = OP_DEC;
                    reg_operand(y, d.first_kind, d.first_value);
                end
                3'd6: begin
                    d.operation = OP_LD;
                    reg_operand(y, d.first_kind, d.first_value);
                    d.second_kind = K_IMM8; d.second_value = b1;
                end
                default: d.operation = rot[y];
            endcase
        end else begin
            case (z)
                3'd0: begin
                    if (y < 3'd4) begin
                        d.operation = OP_RET; d.condition = y + 3'd1;
                    end else if (y == 3'd4) begin
                        d.operation = OP_LDH;
                        d.first_kind = K_ADDR; d.first_value = b1;
                        d.second_kind = K_REG; d.second_value = R_A;
                    end else if (y == 3'd6) begin
                        d.operation = OP_LDH;
                        d.first_kind = K_REG; d.first_value = R_A;
                        d.second_kind = K_ADDR; d.second_value = b1;
                    end else begin
                        d.operation = (y == 3'd5) ? OP_ADD : OP_LDHL;
                        d.first_kind = K_PAIR; d.first_value = P_SP;
                        d.second_kind = K_IMM8; d.second_value = b1;
                    end
                end
                3'd1: begin
                    if (!q) begin
                        d.operation = OP_POP;
                        d.first_kind = K_PAIR; d.first_value = pr_af;
                    end else if (p == 2'd0) begin
                        d.operation = OP_RET;
                    end else if (p == 2'd1) begin
                        d.operation = OP_RETI;
                    end else if (p == 2'd2) begin
                        d.operation = OP_JP;
                        d.first_kind = K_IND; d.first_value = P_HL;
                    end else begin
                        d.operation = OP_LD;
                        d.first_kind = K_PAIR; d.first_value = P_SP;
                        d.second_kind = K_PAIR; d.second_value = P_HL;
                    end
                end
                3'd2: begin
                    if (y < 3'd4) begin
                        d.operation = OP_JP; d.condition = y + 3'd1;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                    end else if (y == 3'd4 || y == 3'd6) begin
                        d.operation = OP_LDH;
                        d.first_kind = K_REG;
                        d.first_value = (y == 3'd4) ? R_C : R_A;
                        d.second_kind = K_REG;
                        d.second_value = (y == 3'd4) ? R_A : R_C;
                    end else if (y == 3'd5) begin
                        d.operation = OP_LD;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                        d.second_kind = K_REG; d.second_value = R_A;
                    end else begin
                        d.operation = OP_LD;
                        d.first_kind = K_REG; d.first_value = R_A;
                        d.second_kind = K_ADDR; d.second_value = imm16;
                    end
                end
                3'd3: begin
                    if (y == 3'd0) begin
                        d.operation = OP_JP;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                    end else if (y == 3'd6) begin
                        d.operation = OP_DI;
                    end else if (y == 3'd7) begin
                        d.operation = OP_EI;
                    end else begin
                        d.illegal = 1'b1;
                    end
                end
                3'd4: begin
                    if (y < 3'd4) begin
                        d.operation = OP_CALL; d.condition = y + 3'd1;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                    end else begin
                        d.illegal = 1'b1;
                    end
                end
                3'd5: begin
                    if (!q) begin
                        d.operation = OP_PUSH;
                        d.first_kind = K_PAIR; d.first_value = pr_af;
                    end else if (p == 2'd0) begin
                        d.operation = OP_CALL;
                        d.first_kind = K_ADDR; d.first_value = imm16;
                    end else begin
                        d.illegal = 1'b1;
                    end
                end
                default: begin
                    d.operation = OP_RST;
                    d.first_kind = K_ADDR; d.first_value = {10'd0, y, 3'd0};
                end
            endcase
        end
        // Undefined opcodes carry nothing but the flag
        if (d.illegal) begin
            d = '0;
            d.illegal = 1'b1;
        end
        return d;
    endfunction

    assign pending_count = decoded_queue.size();

    // Predict on input handshake, compare on output handshake
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) decoded_queue.push_back(decode_instr(s_data));
            if (m_valid && m_ready) begin
                if (decoded_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = decoded_queue.pop_front();
                    if (want !== m_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                        if (want.illegal !== m_data.illegal)
                            $display("  illegal exp %0d act %0d", want.illegal, m_data.illegal);
                        if (want.operation !== m_data.operation)
                            $display("  operation exp %0d act %0d", want.operation,
                                     m_data.operation);
                        if (want.condition !== m_data.condition)
                            $display("  condition exp %0d act %0d", want.condition,
                                     m_data.condition);
                        if (want.first_kind !== m_data.first_kind ||
                            want.first_value !== m_data.first_value)
                            $display("  first exp %0d/%h act %0d/%h", want.first_kind,
                                     want.first_value, m_data.first_kind, m_data.first_value);
                        if (want.second_kind !== m_data.second_kind ||
                            want.second_value !== m_data.second_value)
                            $display("  second exp %0d/%h act %0d/%h", want.second_kind,
                                     want.second_value, m_data.second_kind,
                                     m_data.second_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/eight_bit_cpu_instruction_decoder_top_tb.sv =====
module eight_bit_cpu_instruction_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ebcid_pkg::*;

    localparam int RANDOM_ITEMS = 700;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    int        fail_count;
    int        pending_count;
    bit        calm_phase = 1'b0;
    bit        hold_off = 1'b0;

    always #10 aclk = ~aclk;

    eight_bit_cpu_instruction_decoder_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    decoder_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Offer one item and hold it until accepted
    task automatic send_instr(input logic [7:0] opc, input logic [7:0] b1,
                              input logic [7:0] b2);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{opcode_byte: opc, second_byte: b1, third_byte: b2};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: random stall bursts, or one long hold-off on request
    initial begin
        int n;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (40) @(negedge aclk);
                hold_off = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin
        logic [7:0] opc;
        logic [7:0] illegal_codes [12];
        illegal_codes = '{8'hCB, 8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB, 8'hEC,
                          8'hED, 8'hF4, 8'hFC, 8'hFD};
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed: operand extremes, halt, prefix and undefined codes, ops
        send_instr(8'h00, 8'h00, 8'h00);
        send_instr(8'hFF, 8'hFF, 8'hFF);
        send_instr(8'h76, 8'hAA, 8'h55);
        send_instr(8'hCB, 8'hFF, 8'hFF);
        send_instr(8'hDD, 8'h12, 8'h34);
        send_instr(8'h01, 8'hFF, 8'h00);
        send_instr(8'h08, 8'h00, 8'hFF);
        send_instr(8'h18, 8'h80, 8'h00);
        send_instr(8'h38, 8'h7F, 8'h00);
        send_instr(8'hE0, 8'hFF, 8'h00);
        send_instr(8'hF8, 8'h80, 8'h00);
        send_instr(8'hE2, 8'h00, 8'h00);
        send_instr(8'hC7, 8'h00, 8'h00);
        send_instr(8'hE9, 8'h00, 8'h00);
        send_instr(8'hCE, 8'h5A, 8'hA5);
        send_instr(8'hD6, 8'h01, 8'h02);
        send_instr(8'h7E, 8'h00, 8'h00);
        send_instr(8'h10, 8'h00, 8'h00);
        // Walk every opcode once
        for (int i = 0; i < 256; i++)
            send_instr(i[7:0], 8'($urandom), 8'($urandom));
        // Hold off the receiver while the sender keeps going
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            send_instr(8'($urandom), 8'($urandom), 8'($urandom));
        // Pause the sender until everything has drained
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        // Random: mostly defined opcodes, some undefined ones
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 150) calm_phase = 1'b1;
            opc = 8'($urandom);
            if ($urandom_range(0, 15) == 0) opc = illegal_codes[$urandom_range(0, 11)];
            send_instr(opc, 8'($urandom), 8'($urandom));
        end
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
